[rtl/cobs_frame_encoder_macros.svh]
// ----------------------------------------------------------------------------
// cobs frame encoder assertion macros
// shared clocked assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef COBS_FRAME_ENCODER_MACROS_SVH
`define COBS_FRAME_ENCODER_MACROS_SVH

// checked outside reset only
`define CFE_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define CFE_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/cfe_pkg.sv]
// ----------------------------------------------------------------------------
// cfe_pkg
// shared types and constants of the cobs frame encoder
// ----------------------------------------------------------------------------
package cfe_pkg;

   localparam int WORD_BYTES = 8;
   localparam logic [7:0] CODE_EMPTY = 8'h01;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_FILL
   } cfe_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic rd;
      logic load;
   } cfe_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic emit_now;
      logic last_word;
      logic out_free;
   } cfe_sts_type;

endpackage

[rtl/cobs_frame_encoder.sv]
// a byte closing no block is taken in idle and the next byte may follow; a closing
// byte moves on to read, which primes the store, and fill, which loads its words;
// input stalls until its last word is loaded; 1 to 32 words, one per cycle while the
// result side does not stall, set by the row-organized run store's one read port
// reset: synchronous, clears the sequencer, run length and result valid
// ----------------------------------------------------------------------------
// cobs_frame_encoder
// cobs encoder with 0xff block splitting, packs encoded bytes into 8-byte words
// ----------------------------------------------------------------------------
module cobs_frame_encoder
   import cfe_pkg::*;
#(
   parameter int MAX_RUN = 254
) (
   input  logic       clock,
   input  logic       reset,
   // raw byte items
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_frame_end,
   // encoded word items
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte0,
   output logic [7:0] rsp_out_byte1,
   output logic [7:0] rsp_out_byte2,
   output logic [7:0] rsp_out_byte3,
   output logic [7:0] rsp_out_byte4,
   output logic [7:0] rsp_out_byte5,
   output logic [7:0] rsp_out_byte6,
   output logic [7:0] rsp_out_byte7,
   output logic [3:0] rsp_byte_count,
   output logic       rsp_last_of_run,
   output logic       rsp_frame_done
);

   // command and status between sequencer and datapath
   cfe_cmd_type cmd;
   cfe_sts_type sts;

   // sequencer: idle takes an item, read primes the store, fill drains words
   cfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: nonzero bytes are gathered into 8-byte rows, full rows go to
   // the run store, the open row stays in a buffer; each word is the code
   // byte or last byte of the previous row followed by 7 bytes of this row
   cfe_dpath #(
      .MAX_RUN (MAX_RUN)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_data_byte),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte0   (rsp_out_byte0),
      .rsp_out_byte1   (rsp_out_byte1),
      .rsp_out_byte2   (rsp_out_byte2),
      .rsp_out_byte3   (rsp_out_byte3),
      .rsp_out_byte4   (rsp_out_byte4),
      .rsp_out_byte5   (rsp_out_byte5),
      .rsp_out_byte6   (rsp_out_byte6),
      .rsp_out_byte7   (rsp_out_byte7),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_done  (rsp_frame_done),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule

[rtl/cfe_ram.sv]
// ----------------------------------------------------------------------------
// cfe_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module cfe_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/cfe_ctrl.sv]
// ----------------------------------------------------------------------------
// cfe_ctrl
// sequencer: takes an item, then drains its encoded words
// ----------------------------------------------------------------------------
module cfe_ctrl
   import cfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  cfe_sts_type sts,
   output cfe_cmd_type cmd
);

   cfe_state_type state_ff;
   cfe_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.emit_now) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // first row read of the block
            cmd.rd   = 1'b1;
            state_in = ST_FILL;
         end
         ST_FILL: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               if (sts.last_word) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/cfe_dpath.sv]
// ----------------------------------------------------------------------------
// cfe_dpath
// run store, row assembly, word packing and output register
// ----------------------------------------------------------------------------
module cfe_dpath
   import cfe_pkg::*;
#(
   parameter int MAX_RUN = 254
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte0,
   output logic [7:0]  rsp_out_byte1,
   output logic [7:0]  rsp_out_byte2,
   output logic [7:0]  rsp_out_byte3,
   output logic [7:0]  rsp_out_byte4,
   output logic [7:0]  rsp_out_byte5,
   output logic [7:0]  rsp_out_byte6,
   output logic [7:0]  rsp_out_byte7,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_last_of_run,
   output logic        rsp_frame_done,
   input  cfe_cmd_type cmd,
   output cfe_sts_type sts
);

   localparam int RLW   = ($clog2(MAX_RUN + 1) < 4) ? 4 : $clog2(MAX_RUN + 1);
   localparam int ROWS  = (MAX_RUN + WORD_BYTES - 1) / WORD_BYTES;
   localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int WORDS = (MAX_RUN + 2 + WORD_BYTES - 1) / WORD_BYTES;
   localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CW    = (WIW + 3 > RLW) ? WIW + 3 : RLW + 1;
   localparam int RBW   = 8 * WORD_BYTES;

   // block state
   logic [RLW-1:0] run_len_ff, run_len_in;
   logic [RBW-1:0] row_buf_ff, row_buf_in;
   logic [RLW-1:0] n_ff;
   logic           extra_ff;
   logic           fin_ff;
   logic [WIW-1:0] last_idx_ff;
   logic [3:0]     last_cnt_ff;
   logic [WIW-1:0] word_idx_ff, word_idx_in;
   logic [7:0]     prev_hi_ff;

   // output register
   logic           rsp_valid_ff;
   logic [7:0]     out_ff [WORD_BYTES];
   logic [3:0]     count_ff;
   logic           last_ff;
   logic           done_ff;

   // accept path
   logic           nz;
   logic [RLW-1:0] n_new;
   logic           full;
   logic           close;
   logic           extra;
   logic [CW-1:0]  tot_m1;

   // store port
   logic           wr_en;
   logic [RAW-1:0] wr_addr;
   logic [RBW-1:0] wr_data;
   logic           rd_en;
   logic [RAW-1:0] rd_addr;
   logic [RBW-1:0] mem_rdata;

   // word build
   logic [CW-1:0]      base;
   logic [CW-1:0]      n_c;
   logic [CW-1:0]      pos;
   logic [RBW-1:0]     row_sel;
   logic [RBW+7:0]     shifted;
   logic [7:0]         code;
   logic [7:0]         lane_in [WORD_BYTES];
   logic               last_word;
   logic               out_free;

   always_comb begin
      nz     = |req_data_byte;
      n_new  = run_len_ff + RLW'(nz);
      full   = nz && (n_new == RLW'(MAX_RUN));
      close  = !nz || full || req_frame_end;
      extra  = req_frame_end && (!nz || full);
      tot_m1 = CW'(n_new) + CW'(extra);
   end

   always_comb begin
      row_buf_in = row_buf_ff;
      row_buf_in[8 * run_len_ff[2:0] +: 8] = req_data_byte;
   end

   // a row goes to the store as its eighth byte comes in
   assign wr_en   = cmd.accept && nz && (run_len_ff[2:0] == 3'd7);
   assign wr_addr = RAW'(run_len_ff >> 3);
   assign wr_data = {req_data_byte, row_buf_ff[RBW-9:0]};

   assign last_word = (word_idx_ff == last_idx_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      word_idx_in = word_idx_ff;
      if (cmd.accept) begin
         word_idx_in = '0;
      end else if (cmd.load) begin
         word_idx_in = word_idx_ff + WIW'(1);
      end
   end

   // prefetch the next row while a word is loaded
   assign rd_en   = cmd.rd || (cmd.load && !last_word);
   assign rd_addr = RAW'(word_idx_in);

   cfe_ram #(
      .WIDTH (RBW),
      .DEPTH (ROWS)
   ) u_run_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      base    = CW'({word_idx_ff, 3'b000});
      n_c     = CW'(n_ff);
      code    = 8'(n_ff) + 8'd1;
      // full rows sit in the store, the open row in the assembly buffer
      row_sel = (CW'(word_idx_ff) < CW'(n_ff >> 3)) ? mem_rdata : row_buf_ff;
      shifted = {row_sel, prev_hi_ff};
      pos     = '0;
      for (int k = 0; k < WORD_BYTES; k++) begin
         pos = base + CW'(k);
         if (pos == '0) begin
            lane_in[k] = code;
         end else if (pos <= n_c) begin
            lane_in[k] = shifted[8 * k +: 8];
         end else if (extra_ff && (pos == n_c + CW'(1))) begin
            lane_in[k] = CODE_EMPTY;
         end else begin
            lane_in[k] = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            run_len_ff <= run_len_in;
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign run_len_in = close ? '0 : n_new;

   always_ff @(posedge clock) begin
      word_idx_ff <= word_idx_in;
      if (cmd.accept) begin
         if (nz) begin
            row_buf_ff <= row_buf_in;
         end
         n_ff        <= n_new;
         extra_ff    <= extra;
         fin_ff      <= req_frame_end;
         last_idx_ff <= WIW'(tot_m1 >> 3);
         last_cnt_ff <= 4'(tot_m1[2:0]) + 4'd1;
      end
      if (cmd.load) begin
         out_ff     <= lane_in;
         count_ff   <= last_word ? last_cnt_ff : 4'(WORD_BYTES);
         last_ff    <= last_word;
         done_ff    <= last_word && fin_ff;
         prev_hi_ff <= row_sel[RBW-1 -: 8];
      end
   end

   assign sts.emit_now  = close;
   assign sts.last_word = last_word;
   assign sts.out_free  = out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte0   = out_ff[0];
   assign rsp_out_byte1   = out_ff[1];
   assign rsp_out_byte2   = out_ff[2];
   assign rsp_out_byte3   = out_ff[3];
   assign rsp_out_byte4   = out_ff[4];
   assign rsp_out_byte5   = out_ff[5];
   assign rsp_out_byte6   = out_ff[6];
   assign rsp_out_byte7   = out_ff[7];
   assign rsp_byte_count  = count_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_frame_done  = done_ff;

endmodule

[rtl/cfe_checker.sv]
// ----------------------------------------------------------------------------
// cfe_checker
// port level checks on the encoded word stream
// ----------------------------------------------------------------------------
`include "cobs_frame_encoder_macros.svh"

module cfe_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte0,
   input logic [7:0] rsp_out_byte7,
   input logic [3:0] rsp_byte_count,
   input logic       rsp_last_of_run,
   input logic       rsp_frame_done
);

   // a stalled word holds
   `CFE_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte0) && $stable(rsp_byte_count), "stalled word changed")

   // a word carries one to eight bytes
   `CFE_ASSERT(a_count_range, rsp_valid |-> (rsp_byte_count != 4'd0) && (rsp_byte_count <= 4'd8), "byte count out of range")

   // the frame closes on the last word of an item
   `CFE_ASSERT(a_done_last, rsp_valid && rsp_frame_done |-> rsp_last_of_run, "frame done without last of run")

   // the top lane is zero whenever the count is below eight
   `CFE_ASSERT(a_unused_lane, rsp_valid && (rsp_byte_count != 4'd8) |-> rsp_out_byte7 == 8'd0, "unused lane not zero")

   // no word right after reset
   `CFE_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "word valid after reset")

endmodule

bind cobs_frame_encoder cfe_checker u_cfe_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte0   (rsp_out_byte0),
   .rsp_out_byte7   (rsp_out_byte7),
   .rsp_byte_count  (rsp_byte_count),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_frame_done  (rsp_frame_done)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobs frame encoder testbench
// streams raw frame bytes into the encoder and compares every encoded word
// with a local cobs encoder that splits runs at 254 bytes
// ----------------------------------------------------------------------------
module tb_top;
   import cfe_pkg::*;

   localparam int MAX_RUN = 254;

   // one encoded word as the block should deliver it
   typedef struct {
      logic [7:0] lane [WORD_BYTES];
      logic [3:0] count;
      logic       last;
      logic       done;
   } enc_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_frame_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte0;
   logic [7:0] rsp_out_byte1;
   logic [7:0] rsp_out_byte2;
   logic [7:0] rsp_out_byte3;
   logic [7:0] rsp_out_byte4;
   logic [7:0] rsp_out_byte5;
   logic [7:0] rsp_out_byte6;
   logic [7:0] rsp_out_byte7;
   logic [3:0] rsp_byte_count;
   logic       rsp_last_of_run;
   logic       rsp_frame_done;

   // local encoder state: the open block of nonzero bytes
   logic [7:0]   run_buf [MAX_RUN];
   int unsigned  run_len = 0;
   logic [7:0]   enc_stream [$];
   enc_word_type encoded_words_q [$];

   // pacing knobs, written by the test tasks only
   bit          tx_gaps_on = 1'b1;
   bit          rx_stalls_on = 1'b1;
   int unsigned hold_len = 0;
   int unsigned hold_ticket = 0;

   // receiver side bookkeeping, each written by one process
   bit          rsp_took = 1'b0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   int unsigned stall_left = 0;
   int unsigned err_count = 0;

   cobs_frame_encoder #(
      .MAX_RUN(MAX_RUN)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_frame_end  (req_frame_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte0  (rsp_out_byte0),
      .rsp_out_byte1  (rsp_out_byte1),
      .rsp_out_byte2  (rsp_out_byte2),
      .rsp_out_byte3  (rsp_out_byte3),
      .rsp_out_byte4  (rsp_out_byte4),
      .rsp_out_byte5  (rsp_out_byte5),
      .rsp_out_byte6  (rsp_out_byte6),
      .rsp_out_byte7  (rsp_out_byte7),
      .rsp_byte_count (rsp_byte_count),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_frame_done (rsp_frame_done)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // local encoder
   // ---------------------------------------------------------------------------

   // code byte (held length plus one), then the held bytes
   function automatic void close_run();
      enc_stream.push_back(8'(run_len + 1));
      for (int i = 0; i < run_len; i++) begin
         enc_stream.push_back(run_buf[i]);
      end
      run_len = 0;
   endfunction

   // encode one accepted byte and queue the words it should produce
   function automatic void encode_byte(input logic [7:0] b, input logic fin);
      int unsigned  n_words;
      int unsigned  base;
      int unsigned  cnt;
      enc_word_type w;
      enc_stream.delete();
      if (b == 8'h00) begin
         close_run();
      end else begin
         run_buf[run_len] = b;
         run_len++;
         // a full run closes with code 0xff
         if (run_len >= MAX_RUN) begin
            close_run();
         end
      end
      // frame end closes whatever is open, even an empty block
      if (fin) begin
         close_run();
      end
      n_words = (enc_stream.size() + WORD_BYTES - 1) / WORD_BYTES;
      for (int unsigned wi = 0; wi < n_words; wi++) begin
         base = wi * WORD_BYTES;
         cnt = enc_stream.size() - base;
         if (cnt > WORD_BYTES) begin
            cnt = WORD_BYTES;
         end
         // unused lanes read as zero
         for (int k = 0; k < WORD_BYTES; k++) begin
            w.lane[k] = (k < cnt) ? enc_stream[base + k] : 8'h00;
         end
         w.count = 4'(cnt);
         w.last = (wi + 1 == n_words);
         w.done = w.last && fin;
         encoded_words_q.push_back(w);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // result side: checker and stall driver
   // ---------------------------------------------------------------------------

   // compare each accepted word with the oldest queued one
   always @(posedge clock) begin : check_words
      logic [7:0]   seen [WORD_BYTES];
      enc_word_type want;
      rsp_took = 1'b0;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_took = 1'b1;
         seen = '{rsp_out_byte0, rsp_out_byte1, rsp_out_byte2, rsp_out_byte3,
                  rsp_out_byte4, rsp_out_byte5, rsp_out_byte6, rsp_out_byte7};
         if (encoded_words_q.size() == 0) begin
            $error("unexpected result word, byte_count %0d", rsp_byte_count);
            err_count++;
         end else begin
            want = encoded_words_q.pop_front();
            for (int k = 0; k < WORD_BYTES; k++) begin
               if (seen[k] !== want.lane[k]) begin
                  $error("out_byte%0d expected %h actual %h", k, want.lane[k], seen[k]);
                  err_count++;
               end
            end
            if (rsp_byte_count !== want.count) begin
               $error("byte_count expected %0d actual %0d", want.count, rsp_byte_count);
               err_count++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run expected %b actual %b", want.last, rsp_last_of_run);
               err_count++;
            end
            if (rsp_frame_done !== want.done) begin
               $error("frame_done expected %b actual %b", want.done, rsp_frame_done);
               err_count++;
            end
         end
      end
   end

   // stall pattern: a fresh random wait after each taken word if enabled, long holds on request
   always @(negedge clock) begin
      if (hold_ticket != hold_served) begin
         hold_served = hold_ticket;
         hold_left = hold_len;
      end
      if (rsp_took) begin
         stall_left = rx_stalls_on ? $urandom_range(0, 15) : 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------------
   // input side
   // ---------------------------------------------------------------------------

   // offer one byte after a random gap when gaps are on and wait until it is taken
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int unsigned gap;
      gap = tx_gaps_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_frame_end <= fin;
      do @(posedge clock); while (req_stall);
      encode_byte(b, fin);
   endtask

   // drop valid before anything other than another byte follows
   task automatic req_idle();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // hold the sender until every queued word has come back
   task automatic drain_results();
      while (encoded_words_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] nonzero_byte();
      return 8'($urandom_range(1, 255));
   endfunction

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // short frames covering extremes and the corner cases of the scheme
   task automatic test_directed();
      // zero at frame end: closed block then a final empty block
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      // bytes that close nothing, then a zero, then frame end
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7f, 1'b1);
      // back to back zeros
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      // ten encoded bytes, spread over two words
      for (int i = 1; i <= 9; i++) begin
         send_byte(8'h55 ^ 8'(i), i == 9);
      end
      send_byte(8'haa, 1'b0);
      send_byte(8'h00, 1'b1);
      req_idle();
      drain_results();
   endtask

   // a run of the split length, the largest item in words
   task automatic test_long_runs();
      tx_gaps_on = 1'b0;
      // full run at frame end: 0xff block then a final empty block
      for (int i = 0; i < MAX_RUN; i++) begin
         send_byte(nonzero_byte(), i == MAX_RUN - 1);
      end
      req_idle();
      drain_results();
      tx_gaps_on = 1'b1;
   endtask

   // long receiver hold while the sender keeps pushing bytes, every second one a closing zero
   task automatic test_backpressure();
      tx_gaps_on = 1'b0;
      rx_stalls_on = 1'b0;
      hold_len = 300;
      hold_ticket++;
      for (int i = 0; i < 16; i++) begin
         send_byte((i % 2 != 0) ? 8'h00 : nonzero_byte(), i == 15);
      end
      req_idle();
      drain_results();
      tx_gaps_on = 1'b1;
      rx_stalls_on = 1'b1;
   endtask

   // random short frames with a varying share of zero bytes
   task automatic test_random_frames();
      int unsigned sent;
      int unsigned flen;
      int unsigned zero_pct;
      logic [7:0]  b;
      sent = 0;
      while (sent < 160) begin
         // pacing changes per frame, including stretches with no idling at all
         tx_gaps_on = ($urandom_range(0, 3) != 0);
         rx_stalls_on = ($urandom_range(0, 3) != 0);
         flen = $urandom_range(1, 20);
         zero_pct = ($urandom_range(0, 3) == 0) ? 50 : 12;
         for (int i = 0; i < flen; i++) begin
            b = ($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom_range(0, 255));
            send_byte(b, i == flen - 1);
         end
         sent += flen;
         // sender pause until every queued word has come back
         if ($urandom_range(0, 7) == 0) begin
            req_idle();
            drain_results();
         end
      end
      req_idle();
      drain_results();
      tx_gaps_on = 1'b1;
      rx_stalls_on = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_long_runs();
      test_backpressure();
      test_random_frames();
      // let any stray word surface before the verdict
      repeat (64) @(posedge clock);
      if (err_count == 0 && encoded_words_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
